@@ rtl/tfrm_pkg.sv @@
package tfrm_pkg;

  // Field widths
  localparam int TF_W    = 13;  // texel count / width register
  localparam int RES_W   = 7;   // bin count / resolution register
  localparam int ALPHA_W = 8;
  localparam int QV_W    = 17;  // Q1.16 query bound, one integer bit for 1.0
  localparam int FRAC_W  = 16;

  localparam logic [QV_W-1:0] QV_ONE     = QV_W'(65536);
  localparam logic [QV_W-1:0] ROUND_HALF = QV_W'(32768);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_TF_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RES  = CFG_IDX_W'(1);

  localparam logic [TF_W-1:0]  TF_WIDTH_RST = TF_W'(256);
  localparam logic [RES_W-1:0] MAX_RES_RST  = RES_W'(64);

  // Commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Parameter defaults
  localparam int MAX_TEXELS_DEF = 4096;
  localparam int MAX_BINS_DEF   = 64;

  // Divider steps, one quotient bit per cycle
  localparam int DIV_STEP_W = $clog2(TF_W + 1);

  typedef struct packed {
    logic             done;
    logic [TF_W-1:0]  quot;
    logic [RES_W-1:0] rem;
  } div_res_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } query_rd_t;

endpackage

@@ rtl/transfer_function_range_max_1d_core.sv @@
// Channel   Ports                                        Handshake
// config    cfg_we, cfg_index, cfg_wdata                 write when cfg_we high
// input     in_cmd, in_alpha, in_query_low/high          taken when start & !busy
// result    out_max_alpha, out_table_ready               one cycle under out_strobe
//
// Most loads are taken without going busy. The first load after reset or a
// register write also runs the width/resolution divider, keeping the block busy.
// The last load starts the table build, which keeps the block busy, with one
// table word written per cycle through the table memory's write port.
// Queries do not set busy; results are registered in the query unit and output.
// Reset is synchronous; the table needs no clearing pass, since the build
// rewrites every entry a query can reach before the table is marked ready.
// The receiver cannot stall results.
module transfer_function_range_max_1d_core #(
  parameter int MAX_TEXELS = tfrm_pkg::MAX_TEXELS_DEF,
  parameter int MAX_BINS   = tfrm_pkg::MAX_BINS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tfrm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tfrm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_cmd,
  input  logic [tfrm_pkg::ALPHA_W-1:0]        in_alpha,
  input  logic [tfrm_pkg::QV_W-1:0]           in_query_low,
  input  logic [tfrm_pkg::QV_W-1:0]           in_query_high,
  output logic                                out_strobe,
  output logic [tfrm_pkg::ALPHA_W-1:0]        out_max_alpha,
  output logic                                out_table_ready
);

  localparam int TW     = tfrm_pkg::TF_W;
  localparam int RW     = tfrm_pkg::RES_W;
  localparam int AW     = tfrm_pkg::ALPHA_W;
  localparam int BIN_AW = $clog2(MAX_BINS);
  localparam int TBL_AW = $clog2(MAX_BINS * MAX_BINS);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIRST, S_BUILD} state_t;

  state_t        state_r;
  logic [TW-1:0] tf_width_r;
  logic [RW-1:0] max_res_r;
  logic [TW-1:0] count_r;
  logic [RW-1:0] bin_idx_r;
  logic [RW-1:0] res_use_r;
  logic          built_r;
  logic          first_r;
  logic [AW-1:0] cur_max_r;
  logic [AW-1:0] pend_alpha_r;
  logic [TW-1:0] qw_r;
  logic [RW-1:0] rw_r;
  logic [TW-1:0] q_r;
  logic [RW-1:0] r_r;
  logic [TW-1:0] end_r;

  logic              bld_run_r;
  logic [RW-1:0]     bld_lo_r;
  logic [RW-1:0]     bld_hi_r;
  logic [TBL_AW-1:0] bld_addr_r;
  logic              s2_v_r;
  logic              s2_last_r;
  logic [RW-1:0]     s2_lo_r;
  logic [RW-1:0]     s2_hi_r;
  logic [TBL_AW-1:0] s2_addr_r;
  logic [AW-1:0]     m_r;

  logic oc_v_r;
  logic oc_rdy_r;

  logic [TW-1:0] eff_w;
  logic [RW-1:0] eff_res;
  logic          acc;
  logic          acc_load;
  logic          acc_query;
  logic          div_start;
  logic          load_go;
  logic [AW-1:0] load_alpha;
  logic [AW-1:0] cur_nxt;
  logic          bin_done;
  logic          last_texel;
  logic [RW:0]   r_sum;
  logic          carry;
  logic [RW-1:0] r_nxt;
  logic [TW-1:0] q_nxt;
  logic          bld_last;
  logic [AW-1:0] m_use;
  logic [AW-1:0] tbl_val;

  logic          bin_we;
  logic [AW-1:0] bin_rdata;
  logic [AW-1:0] tbl_rdata;
  logic [TBL_AW-1:0] q_addr;

  tfrm_pkg::div_res_t  div_res;
  tfrm_pkg::query_rd_t q_rd;

  // Last texel of a bin from (b+1)*w = q*res + r
  function automatic logic [TW-1:0] bin_end(input logic [TW-1:0] q,
                                            input logic [RW-1:0] r,
                                            input logic [TW-1:0] w);
    logic [TW-1:0] e;
    e = q + TW'(r != '0) - 1'b1;
    return (e > w - 1'b1) ? w - 1'b1 : e;
  endfunction

  // Clamp the registers to their usable ranges
  always_comb begin
    eff_w = tf_width_r;
    if (tf_width_r == '0) begin
      eff_w = TW'(1);
    end else if (int'(tf_width_r) > MAX_TEXELS) begin
      eff_w = TW'(MAX_TEXELS);
    end
    eff_res = max_res_r;
    if (max_res_r == '0) begin
      eff_res = RW'(1);
    end else if (int'(max_res_r) > MAX_BINS) begin
      eff_res = RW'(MAX_BINS);
    end
    if (TW'(eff_res) > eff_w) begin
      eff_res = RW'(eff_w);
    end
  end

  assign busy      = state_r != S_IDLE;
  assign acc       = start && !busy;
  assign acc_load  = acc && in_cmd == tfrm_pkg::CMD_LOAD;
  assign acc_query = acc && in_cmd == tfrm_pkg::CMD_QUERY;
  assign div_start = acc_load && !built_r && count_r == '0 && !cfg_we;

  // Load path: fold the texel into the open bin
  always_comb begin
    load_alpha = (state_r == S_FIRST) ? pend_alpha_r : in_alpha;
    load_go    = ((acc_load && !built_r && count_r != '0) || state_r == S_FIRST)
                 && bin_idx_r < res_use_r && !cfg_we;
    cur_nxt    = (first_r || load_alpha > cur_max_r) ? load_alpha : cur_max_r;
    bin_done   = count_r == end_r;
    last_texel = ({1'b0, count_r} + 1'b1) >= {1'b0, eff_w};
    bin_we     = load_go && bin_done;
    r_sum      = {1'b0, r_r} + {1'b0, rw_r};
    carry      = r_sum >= {1'b0, res_use_r};
    r_nxt      = carry ? RW'(r_sum - {1'b0, res_use_r}) : r_sum[RW-1:0];
    q_nxt      = q_r + qw_r + TW'(carry);
  end

  // Build path: running maximum along each table row
  always_comb begin
    bld_last = bld_lo_r == res_use_r - 1'b1 && bld_hi_r == res_use_r - 1'b1;
    m_use    = (s2_hi_r == '0) ? '0 : m_r;
    tbl_val  = '0;
    if (s2_hi_r >= s2_lo_r) begin
      tbl_val = (bin_rdata > m_use) ? bin_rdata : m_use;
    end
  end

  tfrm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (eff_w),
    .divisor  (eff_res),
    .res_o    (div_res)
  );

  tfrm_ram #(.WIDTH(AW), .DEPTH(MAX_BINS)) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (BIN_AW'(bin_idx_r)),
    .wdata (cur_nxt),
    .raddr (BIN_AW'(bld_hi_r)),
    .rdata (bin_rdata)
  );

  tfrm_ram #(.WIDTH(AW), .DEPTH(MAX_BINS * MAX_BINS)) u_tbl_ram (
    .clk   (clk),
    .we    (s2_v_r),
    .waddr (s2_addr_r),
    .wdata (tbl_val),
    .raddr (q_addr),
    .rdata (tbl_rdata)
  );

  tfrm_query #(.MAX_BINS(MAX_BINS)) u_query (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (acc_query),
    .query_low   (in_query_low),
    .query_high  (in_query_high),
    .res         (res_use_r),
    .table_ready (built_r),
    .rd          (q_rd),
    .addr        (q_addr)
  );

  // Control, load tracking and build sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      tf_width_r <= tfrm_pkg::TF_WIDTH_RST;
      max_res_r  <= tfrm_pkg::MAX_RES_RST;
      count_r    <= '0;
      bin_idx_r  <= '0;
      res_use_r  <= '0;
      built_r    <= 1'b0;
      first_r    <= 1'b1;
      bld_run_r  <= 1'b0;
      s2_v_r     <= 1'b0;
      oc_v_r     <= 1'b0;
    end else begin
      oc_v_r   <= q_rd.valid;
      oc_rdy_r <= q_rd.ready;

      if (cfg_we) begin
        // Store a known register and restart loading; other indexes do nothing
        unique case (cfg_index)
          tfrm_pkg::REG_TF_WIDTH: begin
            tf_width_r <= cfg_wdata[TW-1:0];
            state_r    <= S_IDLE;
            count_r    <= '0;
            bin_idx_r  <= '0;
            res_use_r  <= '0;
            built_r    <= 1'b0;
            first_r    <= 1'b1;
            bld_run_r  <= 1'b0;
            s2_v_r     <= 1'b0;
          end
          tfrm_pkg::REG_MAX_RES: begin
            max_res_r  <= cfg_wdata[RW-1:0];
            state_r    <= S_IDLE;
            count_r    <= '0;
            bin_idx_r  <= '0;
            res_use_r  <= '0;
            built_r    <= 1'b0;
            first_r    <= 1'b1;
            bld_run_r  <= 1'b0;
            s2_v_r     <= 1'b0;
          end
          default: begin
          end
        endcase
      end else begin
        // Start of a load pass: fix the bin count and split the width
        if (div_start) begin
          res_use_r    <= eff_res;
          bin_idx_r    <= '0;
          first_r      <= 1'b1;
          pend_alpha_r <= in_alpha;
          state_r      <= S_DIV;
        end

        if (state_r == S_DIV && div_res.done) begin
          qw_r    <= div_res.quot;
          rw_r    <= div_res.rem;
          q_r     <= div_res.quot;
          r_r     <= div_res.rem;
          end_r   <= bin_end(div_res.quot, div_res.rem, eff_w);
          state_r <= S_FIRST;
        end

        if (state_r == S_FIRST) begin
          state_r <= S_IDLE;
        end

        // Fold the texel in; close the bin at its last texel
        if (load_go) begin
          count_r <= count_r + 1'b1;
          if (bin_done) begin
            bin_idx_r <= bin_idx_r + 1'b1;
            first_r   <= 1'b1;
            q_r       <= q_nxt;
            r_r       <= r_nxt;
            end_r     <= bin_end(q_nxt, r_nxt, eff_w);
          end else begin
            cur_max_r <= cur_nxt;
            first_r   <= 1'b0;
          end
          if (last_texel) begin
            state_r    <= S_BUILD;
            bld_run_r  <= 1'b1;
            bld_lo_r   <= '0;
            bld_hi_r   <= '0;
            bld_addr_r <= '0;
          end
        end

        // Issue one bin read per cycle, row by row
        s2_v_r <= 1'b0;
        if (state_r == S_BUILD && bld_run_r) begin
          s2_v_r     <= 1'b1;
          s2_last_r  <= bld_last;
          s2_lo_r    <= bld_lo_r;
          s2_hi_r    <= bld_hi_r;
          s2_addr_r  <= bld_addr_r;
          bld_addr_r <= bld_addr_r + 1'b1;
          if (bld_hi_r == res_use_r - 1'b1) begin
            bld_hi_r <= '0;
            bld_lo_r <= bld_lo_r + 1'b1;
          end else begin
            bld_hi_r <= bld_hi_r + 1'b1;
          end
          if (bld_last) begin
            bld_run_r <= 1'b0;
          end
        end

        // Write one table word; the last one finishes the build
        if (s2_v_r) begin
          m_r <= tbl_val;
          if (s2_last_r) begin
            built_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
      end
    end
  end

  assign out_strobe      = oc_v_r;
  assign out_table_ready = oc_rdy_r;
  assign out_max_alpha   = oc_rdy_r ? tbl_rdata : '0;

  // A result strobe follows only an accepted query, via valid_r and oc_v_r
  a_strobe_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(acc_query, 2))
    else $error("result strobe without a query");

  // The table turns ready only out of the build
  a_ready_after_build: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(built_r) |-> $past(state_r) == S_BUILD)
    else $error("table ready without a build");

  // The first load of a pass holds the input off for the divider
  a_busy_on_first_load: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> busy)
    else $error("first load did not start the divider");

  // Texel count never passes the width
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= eff_w)
    else $error("texel count beyond width");

  // Bin writes stay inside the bins in use
  a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    bin_we |-> bin_idx_r < res_use_r)
    else $error("bin write out of range");

endmodule

@@ rtl/tfrm_ram.sv @@
module tfrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tfrm_div.sv @@
module tfrm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tfrm_pkg::TF_W-1:0]     dividend,
  input  logic [tfrm_pkg::RES_W-1:0]    divisor,
  output tfrm_pkg::div_res_t            res_o
);

  localparam int TW = tfrm_pkg::TF_W;
  localparam int RW = tfrm_pkg::RES_W;
  localparam int SW = tfrm_pkg::DIV_STEP_W;

  logic          run_r;
  logic          done_r;
  logic [SW-1:0] step_r;
  logic [TW-1:0] dvd_r;
  logic [RW-1:0] rem_r;
  logic [RW-1:0] dvs_r;

  logic [RW:0]   rem_sh;
  logic          fits;
  logic [RW-1:0] rem_nxt;
  logic [TW-1:0] dvd_nxt;

  // Shift in one dividend bit, subtract when the divisor fits
  always_comb begin
    rem_sh  = {rem_r, dvd_r[TW-1]};
    fits    = rem_sh >= {1'b0, dvs_r};
    rem_nxt = fits ? RW'(rem_sh - {1'b0, dvs_r}) : rem_sh[RW-1:0];
    dvd_nxt = {dvd_r[TW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == SW'(TW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient bits replace the dividend bits as they shift out
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign res_o.done = done_r;
  assign res_o.quot = dvd_r;
  assign res_o.rem  = rem_r;

endmodule

@@ rtl/tfrm_query.sv @@
module tfrm_query #(
  parameter int MAX_BINS = tfrm_pkg::MAX_BINS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  accept,
  input  logic [tfrm_pkg::QV_W-1:0]             query_low,
  input  logic [tfrm_pkg::QV_W-1:0]             query_high,
  input  logic [tfrm_pkg::RES_W-1:0]            res,
  input  logic                                  table_ready,
  output tfrm_pkg::query_rd_t                   rd,
  output logic [$clog2(MAX_BINS*MAX_BINS)-1:0]  addr
);

  localparam int RW  = tfrm_pkg::RES_W;
  localparam int QW  = tfrm_pkg::QV_W;
  localparam int PW  = QW + RW + 1;
  localparam int TAW = $clog2(MAX_BINS * MAX_BINS);

  logic          valid_r;
  logic          ready_r;
  logic [RW-1:0] lo_r;
  logic [RW-1:0] hi_r;
  logic [2*RW:0] sum;

  // Saturate to 1.0, scale by res-1, round halves up
  function automatic logic [RW-1:0] to_index(input logic [QW-1:0] v,
                                             input logic [RW-1:0] r);
    logic [QW-1:0] vs;
    logic [PW-1:0] acc;
    vs  = (v > tfrm_pkg::QV_ONE) ? tfrm_pkg::QV_ONE : v;
    acc = PW'(vs) * PW'(r - 1'b1) + PW'(tfrm_pkg::ROUND_HALF);
    return acc[tfrm_pkg::FRAC_W +: RW];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  // Map both bounds to bin indices
  always_ff @(posedge clk) begin
    if (accept) begin
      ready_r <= table_ready;
      lo_r    <= to_index(query_low, res);
      hi_r    <= to_index(query_high, res);
    end
  end

  // Table row is low, column is high
  assign sum      = (2*RW+1)'(lo_r * res) + (2*RW+1)'(hi_r);
  assign addr     = TAW'(sum);
  assign rd.valid = valid_r;
  assign rd.ready = ready_r;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int ALPHA_W    = tfrm_pkg::ALPHA_W;
  localparam int TF_W       = tfrm_pkg::TF_W;
  localparam int RES_W      = tfrm_pkg::RES_W;
  localparam int QV_W       = tfrm_pkg::QV_W;
  localparam int FRAC_W     = tfrm_pkg::FRAC_W;
  localparam int CFG_IDX_W  = tfrm_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = tfrm_pkg::CFG_DATA_W;

  localparam logic [QV_W-1:0]      QV_ONE       = tfrm_pkg::QV_ONE;
  localparam logic [QV_W-1:0]      ROUND_HALF   = tfrm_pkg::ROUND_HALF;
  localparam logic                 CMD_LOAD     = tfrm_pkg::CMD_LOAD;
  localparam logic                 CMD_QUERY    = tfrm_pkg::CMD_QUERY;
  localparam logic [CFG_IDX_W-1:0] REG_TF_WIDTH = tfrm_pkg::REG_TF_WIDTH;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RES  = tfrm_pkg::REG_MAX_RES;
  localparam logic [TF_W-1:0]      TF_WIDTH_RST = tfrm_pkg::TF_WIDTH_RST;
  localparam logic [RES_W-1:0]     MAX_RES_RST  = tfrm_pkg::MAX_RES_RST;

  localparam int TEXEL_CAP   = tfrm_pkg::MAX_TEXELS_DEF;
  localparam int BIN_CAP     = tfrm_pkg::MAX_BINS_DEF;
  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE      = 8;

  // Indexes that decode to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  typedef struct packed {
    logic [ALPHA_W-1:0] max_alpha;
    logic               ready;
  } range_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  start;
  logic                  busy;
  logic                  in_cmd;
  logic [ALPHA_W-1:0]    in_alpha;
  logic [QV_W-1:0]       in_query_low;
  logic [QV_W-1:0]       in_query_high;
  logic                  out_strobe;
  logic [ALPHA_W-1:0]    out_max_alpha;
  logic                  out_table_ready;

  // Predicted block state
  logic [TF_W-1:0]    reg_width;
  logic [RES_W-1:0]   reg_maxres;
  logic [ALPHA_W-1:0] bin_peak [BIN_CAP];
  int                 texels_seen;
  int                 cur_bin;
  int                 bins_used;
  bit                 table_built;

  range_result_t pending_ranges[$];
  int words_counted = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;
  int burst_left    = 1;

  transfer_function_range_max_1d_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_alpha       (in_alpha),
    .in_query_low   (in_query_low),
    .in_query_high  (in_query_high),
    .out_strobe     (out_strobe),
    .out_max_alpha  (out_max_alpha),
    .out_table_ready(out_table_ready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_width();
    int w;
    w = reg_width;
    if (w < 1) w = 1;
    if (w > TEXEL_CAP) w = TEXEL_CAP;
    return w;
  endfunction

  function automatic int eff_bins();
    int r;
    r = reg_maxres;
    if (r < 1) r = 1;
    if (r > BIN_CAP) r = BIN_CAP;
    return (r < eff_width()) ? r : eff_width();
  endfunction

  // Last texel of bin b, ceiling division in integers
  function automatic int bin_last(int b, int w, int nbins);
    int e;
    e = ((b + 1) * w + nbins - 1) / nbins - 1;
    return (e < w - 1) ? e : w - 1;
  endfunction

  // Saturate the Q1.16 bound and round it onto the bin grid, halves up
  function automatic int bound_to_bin(logic [QV_W-1:0] v, int nbins);
    int s;
    s = (v > QV_ONE) ? int'(QV_ONE) : int'(v);
    return (s * (nbins - 1) + int'(ROUND_HALF)) >> FRAC_W;
  endfunction

  function automatic void clear_prediction();
    foreach (bin_peak[i]) bin_peak[i] = '0;
    texels_seen = 0;
    cur_bin     = 0;
    bins_used   = 0;
    table_built = 1'b0;
  endfunction

  // Advance the predicted state by one accepted word
  function automatic void predict_word(logic cmd, logic [ALPHA_W-1:0] a,
                                       logic [QV_W-1:0] lo, logic [QV_W-1:0] hi);
    int w;
    int first;
    int lo_bin;
    int hi_bin;
    int b;
    range_result_t want;
    if (cmd == CMD_QUERY) begin
      words_counted++;
      want = '0;
      if (table_built) begin
        lo_bin     = bound_to_bin(lo, bins_used);
        hi_bin     = bound_to_bin(hi, bins_used);
        want.ready = 1'b1;
        for (b = lo_bin; b <= hi_bin; b++)
          if (bin_peak[b] > want.max_alpha) want.max_alpha = bin_peak[b];
      end
      pending_ranges.push_back(want);
    end else if (!table_built) begin
      words_counted++;
      w = eff_width();
      if (texels_seen == 0) begin
        bins_used = eff_bins();
        cur_bin   = 0;
      end
      if (cur_bin < bins_used) begin
        first = (cur_bin == 0) ? 0 : bin_last(cur_bin - 1, w, bins_used) + 1;
        if (texels_seen == first || a > bin_peak[cur_bin]) bin_peak[cur_bin] = a;
        if (texels_seen == bin_last(cur_bin, w, bins_used)) cur_bin++;
        texels_seen++;
        if (texels_seen >= w) table_built = 1'b1;
      end
    end
  endfunction

  function automatic void log_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("tb: mismatch %0d: %s", mismatches, what);
  endfunction

  // Present one word, hold it until taken, then maybe open a gap
  task automatic send_word(input logic cmd, input logic [ALPHA_W-1:0] a,
                           input logic [QV_W-1:0] lo, input logic [QV_W-1:0] hi);
    int gap;
    @(negedge clk);
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_alpha      <= a;
    in_query_low  <= lo;
    in_query_high <= hi;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_word(cmd, a, lo, hi);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send_load(input logic [ALPHA_W-1:0] a);
    send_word(CMD_LOAD, a, QV_W'($urandom), QV_W'($urandom));
  endtask

  task automatic send_query(input logic [QV_W-1:0] lo, input logic [QV_W-1:0] hi);
    send_word(CMD_QUERY, ALPHA_W'($urandom), lo, hi);
  endtask

  // Drop start, let results drain and any table build finish
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    repeat (4) @(posedge clk);
    while (pending_ranges.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == REG_TF_WIDTH) begin
      reg_width = data[TF_W-1:0];
      clear_prediction();
    end else if (idx == REG_MAX_RES) begin
      reg_maxres = data[RES_W-1:0];
      clear_prediction();
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Bounds biased toward the ends, past 1.0 and rounding midpoints
  function automatic logic [QV_W-1:0] pick_bound();
    int k;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return QV_ONE;
      2: return QV_W'($urandom_range(QV_ONE + 1, (1 << QV_W) - 1));
      3: begin
        if (bins_used > 1) begin
          k = $urandom_range(0, bins_used - 2);
          return QV_W'(((2 * k + 1) * int'(ROUND_HALF)) / (bins_used - 1)
                       + $urandom_range(0, 1));
        end
        return QV_W'($urandom_range(0, QV_ONE));
      end
      default: return QV_W'($urandom_range(0, QV_ONE));
    endcase
  endfunction

  task automatic run_queries(input int n);
    logic [QV_W-1:0] lo;
    logic [QV_W-1:0] hi;
    logic [QV_W-1:0] t;
    repeat (n) begin
      lo = pick_bound();
      hi = pick_bound();
      if (lo > hi && $urandom_range(0, 9) < 7) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
      send_query(lo, hi);
    end
  endtask

  // Stream n texels, with early queries mixed in as noise
  task automatic load_texels(input int n, input int noise_pct);
    repeat (n) begin
      if ($urandom_range(0, 99) < noise_pct) send_query(pick_bound(), pick_bound());
      send_load(ALPHA_W'($urandom));
    end
  endtask

  // Reset defaults: queries before and during loading, then a full table
  task automatic test_before_build();
    send_query(QV_ONE, '0);
    send_load(8'd0);
    send_load(8'd255);
    send_load(8'd7);
    send_query('0, QV_ONE);
    load_texels(TF_WIDTH_RST - 3, 0);
    send_query('0, QV_ONE);
    send_query(QV_ONE, QV_ONE);
    send_query('1, '0);
  endtask

  // Zero registers act as one texel in one bin; late loads are ignored
  task automatic test_one_texel();
    write_reg(REG_TF_WIDTH, '0);
    write_reg(REG_MAX_RES, '0);
    send_load(8'd255);
    send_query('1, '0);
    send_query('0, '0);
    send_load(8'd0);
    send_query(QV_ONE, QV_ONE);
    // no register behind this index, so the table stays
    write_reg(REG_SPARE, '1);
    send_query('0, QV_ONE);
  endtask

  // Three bins: rounding at midpoints, reversed ranges, saturation
  task automatic test_rounding();
    write_reg(REG_TF_WIDTH, CFG_DATA_W'(3));
    write_reg(REG_MAX_RES, '1);
    send_load(8'd10);
    send_load(8'd200);
    send_load(8'd90);
    send_query(QV_W'(16383), QV_W'(16384));
    send_query(QV_W'(16384), QV_W'(16384));
    send_query(QV_ONE, QV_W'(16384));
    send_query(QV_W'(49151), QV_W'(49152));
    send_query(QV_W'(49152), QV_ONE);
    send_query('0, '1);
  endtask

  // Bin count clamped to the largest with uneven bins, and a single wide bin
  task automatic test_extreme_sizes();
    write_reg(REG_TF_WIDTH, CFG_DATA_W'(BIN_CAP + 1));
    write_reg(REG_MAX_RES, '1);
    load_texels(BIN_CAP + 1, 0);
    run_queries(12);
    write_reg(REG_TF_WIDTH, CFG_DATA_W'(20));
    write_reg(REG_MAX_RES, CFG_DATA_W'(1));
    load_texels(20, 0);
    run_queries(4);
  endtask

  // Random tables: mostly complete loads then queries, some cut short
  task automatic test_random_tables();
    int goal;
    int sel;
    int w;
    int loads;
    bit broken;
    logic [CFG_DATA_W-1:0] res_data;
    goal = words_counted + 30;
    while (words_counted < goal) begin
      sel = $urandom_range(0, 19);
      w = (sel == 0) ? 0 :
          (sel < 14) ? $urandom_range(1, 12) : $urandom_range(13, 40);
      sel = $urandom_range(0, 9);
      res_data = CFG_DATA_W'($urandom);
      res_data[RES_W-1:0] = (sel == 0) ? '0 :
                            (sel < 6) ? RES_W'($urandom_range(1, 16)) : RES_W'($urandom);
      case ($urandom_range(0, 3))
        0: begin
          write_reg(REG_TF_WIDTH, CFG_DATA_W'(w));
          write_reg(REG_MAX_RES, res_data);
        end
        1: begin
          write_reg(REG_MAX_RES, res_data);
          write_reg(REG_TF_WIDTH, CFG_DATA_W'(w));
        end
        2: write_reg(REG_TF_WIDTH, CFG_DATA_W'(w));
        default: write_reg(REG_MAX_RES, res_data);
      endcase
      if ($urandom_range(0, 9) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE : REG_SPARE_HI, CFG_DATA_W'($urandom));
      broken = ($urandom_range(0, 6) == 0);
      loads  = broken ? $urandom_range(0, eff_width() - 1) : eff_width();
      load_texels(loads, 8);
      if (broken) begin
        run_queries($urandom_range(0, 2));
      end else begin
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) send_load(ALPHA_W'($urandom));
        run_queries($urandom_range(4, 12));
      end
    end
  endtask

  // Compare each strobed result with the oldest predicted range
  always @(posedge clk) begin : check_results
    range_result_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_ranges.size() == 0) begin
        log_mismatch($sformatf("unexpected result: max_alpha %0d table_ready %0b",
                               out_max_alpha, out_table_ready));
      end else begin
        want = pending_ranges.pop_front();
        if (out_max_alpha !== want.max_alpha)
          log_mismatch($sformatf("max_alpha expected %0d, got %0d",
                                 want.max_alpha, out_max_alpha));
        if (out_table_ready !== want.ready)
          log_mismatch($sformatf("table_ready expected %0b, got %0b",
                                 want.ready, out_table_ready));
      end
    end
  end

  // Watchdog: end the run after too long with no traffic
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_strobe === 1'b1 || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    start         <= 1'b0;
    in_cmd        <= CMD_LOAD;
    in_alpha      <= '0;
    in_query_low  <= '0;
    in_query_high <= '0;
    reg_width  = TF_WIDTH_RST;
    reg_maxres = MAX_RES_RST;
    clear_prediction();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_before_build();
    test_one_texel();
    test_rounding();
    test_extreme_sizes();
    test_random_tables();

    wait_idle();
    if (mismatches == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tfrm_pkg.sv
rtl/tfrm_ram.sv
rtl/tfrm_div.sv
rtl/tfrm_query.sv
rtl/transfer_function_range_max_1d_core.sv
bench/tb.sv
